// ===== hdl/tetra_barycentric_interp_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tetrahedral barycentric interpolator
// Concurrent checks clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TETRA_BARYCENTRIC_INTERP_ASSERT_SVH
`define TETRA_BARYCENTRIC_INTERP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TBI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TBI_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define TBI_ASSERT(lbl, prop, msg)
`define TBI_NEVER(lbl, cond, msg)
`endif

`endif

// ===== hdl/tbi_pkg.sv =====
// ----------------------------------------------------------------------------
// tbi_pkg
// Types, codes and schedule tables of the tetrahedral barycentric interpolator.
// ----------------------------------------------------------------------------
package tbi_pkg;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_BLEND  = 2'd2;

  localparam logic [1:0] ST_INSIDE  = 2'd0;
  localparam logic [1:0] ST_NORM    = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  localparam logic       KIND_STATUS = 1'b0;
  localparam logic       KIND_VALUE  = 1'b1;

  localparam logic [31:0] ONE_Q31   = 32'h8000_0000;
  localparam int unsigned DIV_STEPS = 31;
  localparam int unsigned NUM_DETS  = 5;
  localparam int unsigned DET_STEPS = 12;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [1:0]         slot;
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
    logic signed [31:0] val0;
    logic signed [31:0] val1;
    logic signed [31:0] val2;
    logic signed [31:0] val3;
  } tbi_req_t;

  typedef struct packed {
    logic               result_kind;
    logic [1:0]         status;
    logic signed [31:0] value;
  } tbi_res_t;

  // Rows of one triple product: vertex numbers and whether vertex 0 is the base
  typedef struct packed {
    logic [1:0] ia;
    logic [1:0] ib;
    logic [1:0] ic;
    logic       edge_base;
  } tbi_rows_t;

  // Determinant 0 is the volume, 1..4 are the sub-volumes of vertices 0..3
  function automatic tbi_rows_t det_rows(logic [2:0] det);
    tbi_rows_t r;
    unique case (det)
      3'd0:    r = '{ia: 2'd1, ib: 2'd2, ic: 2'd3, edge_base: 1'b1};
      3'd1:    r = '{ia: 2'd1, ib: 2'd2, ic: 2'd3, edge_base: 1'b0};
      3'd2:    r = '{ia: 2'd0, ib: 2'd2, ic: 2'd3, edge_base: 1'b0};
      3'd3:    r = '{ia: 2'd1, ib: 2'd0, ic: 2'd3, edge_base: 1'b0};
      3'd4:    r = '{ia: 2'd1, ib: 2'd2, ic: 2'd0, edge_base: 1'b0};
      default: r = '{ia: 2'd0, ib: 2'd0, ic: 2'd0, edge_base: 1'b0};
    endcase
    return r;
  endfunction

  // Cross product schedule: axis of b and of c for steps 0..5
  function automatic logic [1:0] cross_b_axis(logic [3:0] step);
    logic [1:0] a;
    unique case (step)
      4'd0, 4'd5: a = 2'd1;
      4'd1, 4'd2: a = 2'd2;
      default:    a = 2'd0;
    endcase
    return a;
  endfunction

  function automatic logic [1:0] cross_c_axis(logic [3:0] step);
    logic [1:0] a;
    unique case (step)
      4'd0, 4'd3: a = 2'd2;
      4'd1, 4'd4: a = 2'd1;
      default:    a = 2'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/tetra_barycentric_interp.sv =====
// ----------------------------------------------------------------------------
// tetra_barycentric_interp
// Barycentric weights of a point in a tetrahedron and blending of vertex values.
// ----------------------------------------------------------------------------
// A coordinate load is taken and gives no result. A query point runs five
// triple products on one shared 33x33 multiplier and, unless the mesh is
// bad, then four weight divisions at one quotient bit per cycle (a weight of
// exactly 1.0 skips its division), ending in its status result. A blend
// runs four multiply/accumulate pairs on the same multiplier plus rounding.
// busy is high for the whole run; the result is shown for one cycle
// on valid_o and must be taken then, the receiver cannot stall.
`include "tetra_barycentric_interp_assert.svh"

module tetra_barycentric_interp
  import tbi_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  tbi_req_t req_i,
  output logic     valid_o,
  output tbi_res_t res_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ROWS  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_TENV  = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_DIVI  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_BMUL  = 4'd8;
  localparam logic [3:0] S_BACC  = 4'd9;
  localparam logic [3:0] S_BOUT  = 4'd10;

  logic [3:0] state_q, state_d;

  logic signed [19:0] vc_q [4][3];
  logic signed [19:0] vc_d [4][3];
  logic signed [19:0] p_q [3];
  logic signed [19:0] p_d [3];
  logic signed [31:0] val_q [4];
  logic signed [31:0] val_d [4];
  logic [31:0]        w_q [4];
  logic [31:0]        w_d [4];
  logic [1:0]         wst_q, wst_d;

  logic signed [20:0] ra_q [3], rb_q [3], rc_q [3];
  logic signed [20:0] ra_d [3], rb_d [3], rc_d [3];
  logic signed [42:0] cr_q [3];
  logic signed [42:0] cr_d [3];
  logic signed [65:0] prod_q, prod_d;
  logic signed [67:0] acc_q, acc_d;
  logic [63:0]        dm_q [4];
  logic [63:0]        dm_d [4];
  logic [63:0]        v_q, v_d;
  logic [65:0]        s_q, s_d;
  logic [67:0]        tenv_q, tenv_d;
  logic [65:0]        den_q, den_d;
  logic [65:0]        rem_q, rem_d;
  logic [31:0]        quo_q, quo_d;

  logic [3:0] step_q, step_d;
  logic [2:0] det_q, det_d;
  logic [1:0] widx_q, widx_d;
  logic [4:0] cnt_q, cnt_d;

  logic     valid_q, valid_d;
  tbi_res_t res_q, res_d;

  // shared multiplier and its operand select
  logic signed [32:0] opa, opb;
  logic signed [65:0] prod;
  logic               term_shift, term_sub;
  logic signed [67:0] term, acc_sum;
  logic [1:0]         tk;
  logic [63:0]        det_mag;
  logic [1:0]         dm_idx;
  tbi_rows_t          rows;
  logic signed [19:0] base [3];
  logic [66:0]        rem2;
  logic               rem_ge;
  logic [67:0]        rnd;
  logic [36:0]        rsh;

  assign busy    = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  assign tk = 2'((step_q - 4'd6) >> 1);

  always_comb begin
    opa        = '0;
    opb        = '0;
    term_shift = 1'b0;
    term_sub   = 1'b0;
    if (state_q == S_BMUL || state_q == S_BACC) begin
      opa = 33'(val_q[cnt_q[1:0]]);
      opb = $signed({1'b0, w_q[cnt_q[1:0]]});
    end else if (step_q < 4'd6) begin
      opa      = 33'(rb_q[cross_b_axis(step_q)]);
      opb      = 33'(rc_q[cross_c_axis(step_q)]);
      term_sub = step_q[0];
    end else begin
      opa = 33'(ra_q[tk]);
      // high part of the cross product is signed, low part unsigned
      if (!step_q[0]) begin
        opb        = 33'($signed(cr_q[tk][42:32]));
        term_shift = 1'b1;
      end else begin
        opb = $signed({1'b0, cr_q[tk][31:0]});
      end
    end
  end

  assign prod = opa * opb;

  always_comb begin
    if (term_shift) term = $signed({prod_q[35:0], 32'b0});
    else            term = 68'(prod_q);
    acc_sum = term_sub ? (acc_q - term) : (acc_q + term);
  end

  assign det_mag = acc_sum[67] ? 64'(-acc_sum) : acc_sum[63:0];
  assign dm_idx  = 2'(det_q - 3'd1);

  assign rows = det_rows(det_q);
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      base[k] = rows.edge_base ? vc_q[0][k] : p_q[k];
    end
  end

  assign rem2   = {rem_q, 1'b0};
  assign rem_ge = (rem2 >= {1'b0, den_q});

  assign rnd = acc_q + 68'sd1073741824;
  assign rsh = rnd[67:31];

  always_comb begin
    state_d = state_q;
    vc_d    = vc_q;
    p_d     = p_q;
    val_d   = val_q;
    w_d     = w_q;
    wst_d   = wst_q;
    ra_d    = ra_q;
    rb_d    = rb_q;
    rc_d    = rc_q;
    cr_d    = cr_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    dm_d    = dm_q;
    v_d     = v_q;
    s_d     = s_q;
    tenv_d  = tenv_q;
    den_d   = den_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    step_d  = step_q;
    det_d   = det_q;
    widx_d  = widx_q;
    cnt_d   = cnt_q;
    valid_d = 1'b0;
    res_d   = res_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (req_i.req_type)
            REQ_LOAD: begin
              vc_d[req_i.slot][0] = req_i.x;
              vc_d[req_i.slot][1] = req_i.y;
              vc_d[req_i.slot][2] = req_i.z;
            end
            REQ_QUERY: begin
              p_d[0]  = req_i.x;
              p_d[1]  = req_i.y;
              p_d[2]  = req_i.z;
              det_d   = '0;
              s_d     = '0;
              state_d = S_ROWS;
            end
            REQ_BLEND: begin
              val_d[0] = req_i.val0;
              val_d[1] = req_i.val1;
              val_d[2] = req_i.val2;
              val_d[3] = req_i.val3;
              acc_d    = '0;
              cnt_d    = '0;
              state_d  = S_BMUL;
            end
            default: ;
          endcase
        end
      end

      S_ROWS: begin
        for (int k = 0; k < 3; k++) begin
          ra_d[k] = 21'(vc_q[rows.ia][k]) - 21'(base[k]);
          rb_d[k] = 21'(vc_q[rows.ib][k]) - 21'(base[k]);
          rc_d[k] = 21'(vc_q[rows.ic][k]) - 21'(base[k]);
        end
        step_d  = '0;
        acc_d   = '0;
        state_d = S_MUL;
      end

      S_MUL: begin
        prod_d  = prod;
        state_d = S_ACC;
      end

      S_ACC: begin
        acc_d   = acc_sum;
        step_d  = step_q + 4'd1;
        state_d = S_MUL;
        if (step_q < 4'd6 && step_q[0]) begin
          cr_d[step_q[2:1]] = acc_sum[42:0];
          acc_d             = '0;
        end
        if (step_q == 4'(DET_STEPS - 1)) begin
          acc_d = '0;
          if (det_q == 3'd0) begin
            v_d = det_mag;
          end else begin
            dm_d[dm_idx] = det_mag;
            s_d          = s_q + 66'(det_mag);
          end
          if (det_q == 3'(NUM_DETS - 1)) begin
            state_d = S_TENV;
          end else begin
            det_d   = det_q + 3'd1;
            state_d = S_ROWS;
          end
        end
      end

      S_TENV: begin
        tenv_d  = {1'b0, v_q, 3'b0} + {3'b0, v_q, 1'b0};
        state_d = S_CHECK;
      end

      S_CHECK: begin
        widx_d = '0;
        if (v_q == '0 || {2'b0, s_q} >= tenv_d) begin
          wst_d   = ST_BAD;
          for (int i = 0; i < 4; i++) w_d[i] = '0;
          valid_d = 1'b1;
          res_d   = '{result_kind: KIND_STATUS, status: ST_BAD, value: '0};
          state_d = S_IDLE;
        end else if (s_q > {2'b0, v_q}) begin
          wst_d   = ST_NORM;
          den_d   = s_q;
          state_d = S_DIVI;
        end else begin
          wst_d   = ST_INSIDE;
          den_d   = {2'b0, v_q};
          state_d = S_DIVI;
        end
      end

      S_DIVI: begin
        if ({2'b0, dm_q[widx_q]} >= den_q) begin
          w_d[widx_q] = ONE_Q31;
          widx_d      = widx_q + 2'd1;
          if (widx_q == 2'd3) begin
            valid_d = 1'b1;
            res_d   = '{result_kind: KIND_STATUS, status: wst_q, value: '0};
            state_d = S_IDLE;
          end
        end else begin
          rem_d   = {2'b0, dm_q[widx_q]};
          quo_d   = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end

      S_DIV: begin
        rem_d = rem_ge ? 66'(rem2 - {1'b0, den_q}) : rem2[65:0];
        quo_d = {quo_q[30:0], rem_ge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(DIV_STEPS - 1)) begin
          w_d[widx_q] = {quo_q[30:0], rem_ge};
          widx_d      = widx_q + 2'd1;
          state_d     = S_DIVI;
          if (widx_q == 2'd3) begin
            valid_d = 1'b1;
            res_d   = '{result_kind: KIND_STATUS, status: wst_q, value: '0};
            state_d = S_IDLE;
          end
        end
      end

      S_BMUL: begin
        prod_d  = prod;
        state_d = S_BACC;
      end

      S_BACC: begin
        acc_d = acc_sum;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd3) state_d = S_BOUT;
        else               state_d = S_BMUL;
      end

      S_BOUT: begin
        valid_d           = 1'b1;
        res_d.result_kind = KIND_VALUE;
        res_d.status      = wst_q;
        // in range when the bits above 31 are all copies of the sign
        if (rsh[36:31] == '0 || rsh[36:31] == '1) res_d.value = rsh[31:0];
        else if (rsh[36])                        res_d.value = 32'sh8000_0000;
        else                                      res_d.value = 32'sh7fff_ffff;
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      wst_q   <= ST_INSIDE;
      step_q  <= '0;
      det_q   <= '0;
      widx_q  <= '0;
      cnt_q   <= '0;
      for (int i = 0; i < 4; i++) begin
        w_q[i] <= '0;
        for (int k = 0; k < 3; k++) vc_q[i][k] <= '0;
      end
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      wst_q   <= wst_d;
      step_q  <= step_d;
      det_q   <= det_d;
      widx_q  <= widx_d;
      cnt_q   <= cnt_d;
      w_q     <= w_d;
      vc_q    <= vc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    val_q  <= val_d;
    ra_q   <= ra_d;
    rb_q   <= rb_d;
    rc_q   <= rc_d;
    cr_q   <= cr_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    dm_q   <= dm_d;
    v_q    <= v_d;
    s_q    <= s_d;
    tenv_q <= tenv_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    res_q  <= res_d;
  end

  `TBI_NEVER(a_valid_busy, valid_o && busy, "result shown while busy")
  `TBI_ASSERT(a_single_pulse, valid_o |=> !valid_o, "result strobe longer than one cycle")
  `TBI_ASSERT(a_load_quiet, (start && !busy && req_i.req_type == REQ_LOAD) |=> (!busy && !valid_o), "coordinate load started work")
  `TBI_ASSERT(a_status_zero, (valid_o && res_o.result_kind == KIND_STATUS) |-> (res_o.value == '0), "status result with nonzero value")
  `TBI_ASSERT(a_bad_weights, (wst_q == ST_BAD) |-> (w_q[0] == '0 && w_q[1] == '0 && w_q[2] == '0 && w_q[3] == '0), "bad mesh with nonzero weights")

endmodule

// ===== bench/tetra_barycentric_interp_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tetra_barycentric_interp_tb
// Self-checking bench: vertex loads, query points and blends are driven with
// random start gaps; a local model predicts each status and blended value,
// and every strobed result is checked in order against it.
// ----------------------------------------------------------------------------
module tetra_barycentric_interp_tb
  import tbi_pkg::*;
;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 300;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  tbi_req_t req_i;
  logic     valid_o;
  tbi_res_t res_o;

  tbi_req_t pending_reqs[$];
  tbi_res_t expected_res[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned gap_pct = 12;
  logic        req_taken = 1'b0;

  // predictor state
  logic signed [19:0] corner_xyz[12];
  logic [31:0]        wgt[4];
  logic [1:0]         wgt_status;

  tetra_barycentric_interp i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic longint triple(longint a[3], longint b[3], longint c[3]);
    longint cx, cy, cz;
    cx = b[1] * c[2] - b[2] * c[1];
    cy = b[2] * c[0] - b[0] * c[2];
    cz = b[0] * c[1] - b[1] * c[0];
    return a[0] * cx + a[1] * cy + a[2] * cz;
  endfunction

  function automatic logic [63:0] magn(longint d);
    return d < 0 ? 64'(-d) : 64'(d);
  endfunction

  function automatic logic [31:0] q31_ratio(logic [63:0] num, logic [65:0] den);
    logic [97:0] q;
    if ({2'b0, num} >= den) return ONE_Q31;
    q = ({34'b0, num} << 31) / {32'b0, den};
    return q[31:0];
  endfunction

  task automatic update_weights(input longint pt[3]);
    longint rel[4][3];
    longint edg[3][3];
    logic [63:0] dm[4];
    logic [63:0] vm;
    logic [65:0] sum, den;
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 3; k++) rel[i][k] = longint'(corner_xyz[i*3+k]) - pt[k];
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        edg[i][k] = longint'(corner_xyz[(i+1)*3+k]) - longint'(corner_xyz[k]);
    vm    = magn(triple(edg[0], edg[1], edg[2]));
    dm[0] = magn(triple(rel[1], rel[2], rel[3]));
    dm[1] = magn(triple(rel[0], rel[2], rel[3]));
    dm[2] = magn(triple(rel[1], rel[0], rel[3]));
    dm[3] = magn(triple(rel[1], rel[2], rel[0]));
    sum = 66'(dm[0]) + 66'(dm[1]) + 66'(dm[2]) + 66'(dm[3]);
    if (vm == 0 || sum >= 66'(vm) * 10) begin
      wgt_status = ST_BAD;
      for (int i = 0; i < 4; i++) wgt[i] = '0;
      return;
    end
    if (sum > 66'(vm)) begin
      wgt_status = ST_NORM;
      den = sum;
    end else begin
      wgt_status = ST_INSIDE;
      den = 66'(vm);
    end
    for (int i = 0; i < 4; i++) wgt[i] = q31_ratio(dm[i], den);
  endtask

  // Apply one accepted request to the local model; queue its result, if any.
  task automatic predict_request(input tbi_req_t r);
    longint pt[3];
    logic signed [31:0] vals[4];
    logic signed [71:0] acc;
    tbi_res_t res;
    pt[0] = longint'(r.x);
    pt[1] = longint'(r.y);
    pt[2] = longint'(r.z);
    vals = '{r.val0, r.val1, r.val2, r.val3};
    case (r.req_type)
      REQ_LOAD: begin
        corner_xyz[r.slot*3]   = r.x;
        corner_xyz[r.slot*3+1] = r.y;
        corner_xyz[r.slot*3+2] = r.z;
      end
      REQ_QUERY: begin
        update_weights(pt);
        res.result_kind = KIND_STATUS;
        res.status      = wgt_status;
        res.value       = '0;
        expected_res.push_back(res);
      end
      REQ_BLEND: begin
        acc = '0;
        for (int k = 0; k < 4; k++) acc += 72'(vals[k]) * $signed({40'b0, wgt[k]});
        acc = (acc + (72'sd1 <<< 30)) >>> 31;
        if (acc > 72'sh7FFF_FFFF) acc = 72'sh7FFF_FFFF;
        if (acc < -72'sh8000_0000) acc = -72'sh8000_0000;
        res.result_kind = KIND_VALUE;
        res.status      = wgt_status;
        res.value       = acc[31:0];
        expected_res.push_back(res);
      end
      default: ;
    endcase
  endtask

  task automatic add_req(input logic [1:0] rt, input logic [1:0] sl,
                         input int x, input int y, input int z,
                         input int v0, input int v1, input int v2, input int v3);
    tbi_req_t r;
    r.req_type = rt;
    r.slot = sl;
    r.x = 20'(x);
    r.y = 20'(y);
    r.z = 20'(z);
    r.val0 = v0;
    r.val1 = v1;
    r.val2 = v2;
    r.val3 = v3;
    pending_reqs.push_back(r);
  endtask

  function automatic int rnd_coord(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // driver: present a request at the falling edge, hold it until taken
  always @(negedge clk_i) begin
    if (rst_ni && (!start || req_taken)) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= gap_pct) begin
        req_i <= pending_reqs.pop_front();
        start <= 1'b1;
        sent++;
        if (sent == 350) gap_pct = 56;
        if (sent == 700) gap_pct = 0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    tbi_res_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tetra_barycentric_interp regression: fail");
      $finish;
    end else if (rst_ni) begin
      if (valid_o) begin
        if (expected_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", res_o);
        end else begin
          e = expected_res.pop_front();
          if (res_o.result_kind !== e.result_kind || res_o.status !== e.status ||
              res_o.value !== e.value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at cycle %0d: expected kind %0d status %0d value %h,",
                       cycles, e.result_kind, e.status, e.value,
                       " got kind %0d status %0d value %h",
                       res_o.result_kind, res_o.status, res_o.value);
          end
        end
      end
      req_taken <= start && !busy;
      if (start && !busy) predict_request(req_i);
    end
  end

  initial begin
    int span, n, kind;
    start  = 1'b0;
    req_i  = '0;
    rst_ni = 1'b0;
    for (int i = 0; i < 12; i++) corner_xyz[i] = '0;
    for (int i = 0; i < 4; i++) wgt[i] = '0;
    wgt_status = ST_INSIDE;

    // directed part
    add_req(REQ_BLEND, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1, -1);
    add_req(REQ_QUERY, 0, 1, 2, 3, 0, 0, 0, 0);               // zero volume
    add_req(REQ_LOAD, 0, 0, 0, 0, 0, 0, 0, 0);
    add_req(REQ_LOAD, 1, 1024, 0, 0, 0, 0, 0, 0);
    add_req(REQ_LOAD, 2, 0, 1024, 0, 0, 0, 0, 0);
    add_req(REQ_LOAD, 3, 0, 0, 1024, 0, 0, 0, 0);
    add_req(REQ_QUERY, 3, 256, 256, 256, 0, 0, 0, 0);         // inside
    add_req(REQ_BLEND, 1, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 65536, -65536);
    add_req(REQ_QUERY, 0, 1024, 1024, 0, 0, 0, 0, 0);         // normalized
    add_req(REQ_BLEND, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF);
    add_req(REQ_QUERY, 0, 524287, 524287, 524287, 0, 0, 0, 0); // bad mesh
    add_req(REQ_BLEND, 2, 0, 0, 0, 12345, -5, 7, 32'h8000_0000);
    add_req(REQ_UNUSED, 3, -1, -1, -1, -1, -1, -1, -1);
    add_req(REQ_LOAD, 0, -524288, -524288, -524288, 0, 0, 0, 0);
    add_req(REQ_LOAD, 1, 524287, -524288, -524288, 0, 0, 0, 0);
    add_req(REQ_LOAD, 2, -524288, 524287, -524288, 0, 0, 0, 0);
    add_req(REQ_LOAD, 3, -524288, -524288, 524287, 0, 0, 0, 0);
    add_req(REQ_QUERY, 0, -300000, -300000, -300000, 0, 0, 0, 0);
    add_req(REQ_BLEND, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000);
    add_req(REQ_QUERY, 0, -524288, -524288, -524288, 0, 0, 0, 0); // on a corner
    add_req(REQ_BLEND, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0);

    // random part: mostly full tetrahedron/query/blend sequences
    while (pending_reqs.size() < 1050) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        span = ($urandom_range(3) == 0) ? 524287 : int'($urandom_range(8, 4096));
        if ($urandom_range(9) != 0)
          for (int v = 0; v < 4; v++)
            add_req(REQ_LOAD, 2'(v), rnd_coord(span), rnd_coord(span),
                    rnd_coord(span), $urandom, $urandom, $urandom, $urandom);
        n = $urandom_range(1, 3);
        for (int q = 0; q < n; q++) begin
          add_req(REQ_QUERY, 2'($urandom), rnd_coord(span * (1 + $urandom_range(2)) / 2),
                  rnd_coord(span / 2), rnd_coord(span / 2), $urandom, $urandom,
                  $urandom, $urandom);
          repeat ($urandom_range(1, 3))
            add_req(REQ_BLEND, 2'($urandom), $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom);
        end
      end else begin
        add_req(2'($urandom), 2'($urandom), int'($urandom), int'($urandom),
                int'($urandom), $urandom, $urandom, $urandom, $urandom);
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all requests sent and taken once start has dropped with the queue empty
    wait (pending_reqs.size() == 0 && !start && expected_res.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_res.size() == 0)
      $display("tetra_barycentric_interp regression: pass");
    else
      $display("tetra_barycentric_interp regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tbi_pkg.sv
hdl/tetra_barycentric_interp.sv
bench/tetra_barycentric_interp_tb.sv
